/* rtl/core/cpc_pkg.sv */
// Shared types, constants and helper functions of the counter pattern checker.
package cpc_pkg;

  localparam int unsigned OffsetBits  = 40;
  localparam int unsigned ValueBits   = 32;
  localparam int unsigned SkipSumBits = 48;
  localparam int unsigned LimitBits   = 16;
  localparam int unsigned AsmBits     = 24;
  localparam int unsigned AddrBits    = 4;

  typedef enum logic [1:0] {
    WIDTH_8      = 2'd0,
    WIDTH_16     = 2'd1,
    WIDTH_32     = 2'd2,
    WIDTH_32_ALT = 2'd3
  } width_sel_e;

  // Register indexes on the configuration port (word address bits).
  localparam logic [1:0] RegWidthSelect  = 2'd0;
  localparam logic [1:0] RegInitialValue = 2'd1;
  localparam logic [1:0] RegDetailLimit  = 2'd2;

  localparam logic [LimitBits-1:0] DetailLimitReset = 16'd10000;

  // One completed counter, handed from the front end to the statistics unit.
  typedef struct packed {
    logic [OffsetBits-1:0] offset;
    logic [ValueBits-1:0]  expected;
    logic [ValueBits-1:0]  received;
    logic                  mismatch;
    logic [ValueBits-1:0]  skip;
    logic                  restart;
  } cpc_item_t;

  function automatic logic [ValueBits-1:0] width_mask(width_sel_e sel);
    logic [ValueBits-1:0] mask;
    unique case (sel) inside
      WIDTH_8:                mask = 32'h0000_00FF;
      WIDTH_16:               mask = 32'h0000_FFFF;
      WIDTH_32, WIDTH_32_ALT: mask = 32'hFFFF_FFFF;
      default:                mask = 32'hFFFF_FFFF;
    endcase
    return mask;
  endfunction

  // Byte position of the last byte of a counter.
  function automatic logic [1:0] last_phase(width_sel_e sel);
    logic [1:0] ph;
    unique case (sel) inside
      WIDTH_8:                ph = 2'd0;
      WIDTH_16:               ph = 2'd1;
      WIDTH_32, WIDTH_32_ALT: ph = 2'd3;
      default:                ph = 2'd3;
    endcase
    return ph;
  endfunction

endpackage

/* rtl/core/cpc_fifo.sv */
// Small register queue between the byte front end and the statistics unit.
module cpc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(Depth - 1);
  localparam logic [CntBits-1:0] FullCnt = CntBits'(Depth);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/core/cpc_front.sv */
// Byte front end: assembles counters, tracks offsets and compares with the expected value.
module cpc_front import cpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  start_check_i,
  input  width_sel_e            width_sel_i,
  input  logic [ValueBits-1:0]  initial_value_i,
  output logic                  push_o,
  output cpc_item_t             item_o
);

  logic [AsmBits-1:0]    asm_q, asm_d;
  logic [1:0]            phase_q, phase_d;
  logic [OffsetBits-1:0] off_q, off_d;
  logic [ValueBits-1:0]  exp_q, exp_d;
  logic [ValueBits-1:0]  last_q, last_d;
  logic                  pend_q, pend_d;

  logic [ValueBits-1:0]  mask, init_m;
  logic [AsmBits-1:0]    cur_asm;
  logic [1:0]            cur_phase;
  logic [OffsetBits-1:0] cur_off;
  logic [ValueBits-1:0]  cur_exp, cur_last;
  logic [ValueBits-1:0]  gathered, received, skip;
  logic                  complete, mism;

  always_comb begin
    mask      = width_mask(width_sel_i);
    init_m    = initial_value_i & mask;
    // A start drops any partial counter and reloads the expected value.
    cur_asm   = start_check_i ? '0 : asm_q;
    cur_phase = start_check_i ? '0 : phase_q;
    cur_off   = start_check_i ? '0 : off_q;
    cur_exp   = start_check_i ? init_m : exp_q;
    cur_last  = start_check_i ? init_m : last_q;
    complete  = (cur_phase >= last_phase(width_sel_i));
    gathered  = {8'd0, cur_asm} | ({24'd0, data_byte_i} << {cur_phase, 3'b000});
    received  = gathered & mask;
    mism      = (received != cur_exp);
    skip      = mism ? ((received - cur_last) & mask) : '0;

    item_o.offset   = cur_off - OffsetBits'(cur_phase);
    item_o.expected = cur_exp;
    item_o.received = received;
    item_o.mismatch = mism;
    item_o.skip     = skip;
    item_o.restart  = start_check_i || pend_q;
    push_o          = accept_i && complete;

    asm_d   = asm_q;
    phase_d = phase_q;
    off_d   = off_q;
    exp_d   = exp_q;
    last_d  = last_q;
    pend_d  = pend_q;
    if (accept_i) begin
      off_d  = cur_off + 1'b1;
      exp_d  = cur_exp;
      last_d = cur_last;
      if (complete) begin
        asm_d   = '0;
        phase_d = '0;
        exp_d   = (received + 1'b1) & mask;
        last_d  = received;
        pend_d  = 1'b0;
      end else begin
        asm_d   = gathered[AsmBits-1:0];
        phase_d = cur_phase + 1'b1;
        // The statistics are cleared when the next counter reaches the back end.
        pend_d  = pend_q || start_check_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_q   <= '0;
      phase_q <= '0;
      off_q   <= '0;
      exp_q   <= '0;
      last_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      asm_q   <= asm_d;
      phase_q <= phase_d;
      off_q   <= off_d;
      exp_q   <= exp_d;
      last_q  <= last_d;
      pend_q  <= pend_d;
    end
  end

endmodule

/* rtl/core/cpc_back.sv */
// Statistics unit: counts, skip extremes, skip sum, log limiting and the output register.
module cpc_back import cpc_pkg::*; #(
  parameter int unsigned StatBits = 40
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  cpc_item_t              item_i,
  output logic                   pop_o,
  input  logic [LimitBits-1:0]   detail_limit_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [OffsetBits-1:0]  value_offset_o,
  output logic [ValueBits-1:0]   expected_value_o,
  output logic [ValueBits-1:0]   received_value_o,
  output logic                   mismatch_o,
  output logic [ValueBits-1:0]   skip_amount_o,
  output logic                   detail_flag_o,
  output logic                   first_suppressed_o,
  output logic [StatBits-1:0]    good_count_o,
  output logic [StatBits-1:0]    error_count_o,
  output logic [ValueBits-1:0]   min_skip_o,
  output logic [ValueBits-1:0]   max_skip_o,
  output logic [SkipSumBits-1:0] skip_total_o
);

  logic [StatBits-1:0]    good_q, good_d, good_b;
  logic [StatBits-1:0]    err_q, err_d, err_b;
  logic [ValueBits-1:0]   min_q, min_d, min_b;
  logic [ValueBits-1:0]   max_q, max_d, max_b;
  logic [SkipSumBits-1:0] sum_q, sum_d, sum_b;
  logic [SkipSumBits:0]   sum_wide;
  logic [LimitBits-1:0]   logged_q, logged_d, logged_b;
  logic                   sup_q, sup_d, sup_b;
  logic                   detail, first_sup;
  logic                   out_valid_q, out_valid_d;

  logic [OffsetBits-1:0]  off_q;
  logic [ValueBits-1:0]   exp_q, rcv_q, skip_q;
  logic                   mism_q, detail_q, first_sup_q;

  assign pop_o       = item_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = pop_o || (out_valid_q && out_stall_i);

  always_comb begin
    // A restart clears every statistic before this counter is counted.
    good_b   = item_i.restart ? '0 : good_q;
    err_b    = item_i.restart ? '0 : err_q;
    min_b    = item_i.restart ? '0 : min_q;
    max_b    = item_i.restart ? '0 : max_q;
    sum_b    = item_i.restart ? '0 : sum_q;
    logged_b = item_i.restart ? '0 : logged_q;
    sup_b    = item_i.restart ? 1'b0 : sup_q;

    good_d    = good_b;
    err_d     = err_b;
    min_d     = min_b;
    max_d     = max_b;
    sum_d     = sum_b;
    logged_d  = logged_b;
    sup_d     = sup_b;
    detail    = 1'b0;
    first_sup = 1'b0;
    sum_wide  = {1'b0, sum_b} + (SkipSumBits + 1)'(item_i.skip);

    if (!item_i.mismatch) begin
      if (good_b != '1) begin
        good_d = good_b + 1'b1;
      end
    end else begin
      if (err_b == '0) begin
        min_d = item_i.skip;
        max_d = item_i.skip;
      end else begin
        if (item_i.skip < min_b) begin
          min_d = item_i.skip;
        end
        if (item_i.skip > max_b) begin
          max_d = item_i.skip;
        end
      end
      if (err_b != '1) begin
        err_d = err_b + 1'b1;
      end
      sum_d = sum_wide[SkipSumBits] ? '1 : sum_wide[SkipSumBits-1:0];
      if (logged_b < detail_limit_i) begin
        detail   = 1'b1;
        logged_d = logged_b + 1'b1;
      end else if (!sup_b) begin
        first_sup = 1'b1;
        sup_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q      <= '0;
      err_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      logged_q    <= '0;
      sup_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        good_q   <= good_d;
        err_q    <= err_d;
        min_q    <= min_d;
        max_q    <= max_d;
        sum_q    <= sum_d;
        logged_q <= logged_d;
        sup_q    <= sup_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      off_q       <= item_i.offset;
      exp_q       <= item_i.expected;
      rcv_q       <= item_i.received;
      mism_q      <= item_i.mismatch;
      skip_q      <= item_i.skip;
      detail_q    <= detail;
      first_sup_q <= first_sup;
    end
  end

  // The statistics registers double as the output payload: they change only on a pop.
  assign out_valid_o        = out_valid_q;
  assign value_offset_o     = off_q;
  assign expected_value_o   = exp_q;
  assign received_value_o   = rcv_q;
  assign mismatch_o         = mism_q;
  assign skip_amount_o      = skip_q;
  assign detail_flag_o      = detail_q;
  assign first_suppressed_o = first_sup_q;
  assign good_count_o       = good_q;
  assign error_count_o      = err_q;
  assign min_skip_o         = min_q;
  assign max_skip_o         = max_q;
  assign skip_total_o       = sum_q;

endmodule

/* rtl/core/counter_pattern_checker.sv */
// Top level of the counter pattern checker: configuration registers and block wiring.
//
// The checker takes one stream byte per cycle unless in_stall_o holds it, assembles
// little-endian counters of 1, 2 or 4 bytes and, for each completed counter,
// delivers one result with the offset, expected and received values, the skip on
// a mismatch and the running statistics (good and error counts, minimum and
// maximum skip, skip sum). The statistics unit updates all counters for a
// completed counter at once, so it sustains that rate while the output is not
// stalled. The result of a counter is registered in the queue and then in the
// output register. A two-entry queue between the byte front end and the statistics
// unit lets the input keep flowing for a while when the output is stalled. Registers:
// width select at address 0x0, initial value at 0x4 (loaded by a start or by reset
// only), detail limit at 0x8 (reset value 10000).
module counter_pattern_checker import cpc_pkg::*; #(
  parameter int unsigned STAT_COUNT_BITS = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [AddrBits-1:0]        paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       start_check_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [OffsetBits-1:0]      value_offset_o,
  output logic [ValueBits-1:0]       expected_value_o,
  output logic [ValueBits-1:0]       received_value_o,
  output logic                       mismatch_o,
  output logic [ValueBits-1:0]       skip_amount_o,
  output logic                       detail_flag_o,
  output logic                       first_suppressed_o,
  output logic [STAT_COUNT_BITS-1:0] good_count_o,
  output logic [STAT_COUNT_BITS-1:0] error_count_o,
  output logic [ValueBits-1:0]       min_skip_o,
  output logic [ValueBits-1:0]       max_skip_o,
  output logic [SkipSumBits-1:0]     skip_total_o
);

  localparam int unsigned ItemBits = $bits(cpc_item_t);

  width_sel_e           width_sel_q;
  logic [ValueBits-1:0] init_q;
  logic [LimitBits-1:0] limit_q;
  logic                 cfg_write;
  logic [1:0]           reg_idx;

  logic                 accept;
  logic                 fifo_full, fifo_valid, push, pop;
  cpc_item_t            push_item, pop_item;
  logic [ItemBits-1:0]  pop_bits;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      RegWidthSelect:  prdata = {30'd0, width_sel_q};
      RegInitialValue: prdata = init_q;
      RegDetailLimit:  prdata = {16'd0, limit_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_sel_q <= WIDTH_8;
      init_q      <= '0;
      limit_q     <= DetailLimitReset;
    end else if (cfg_write) begin
      unique case (reg_idx)
        RegWidthSelect:  width_sel_q <= width_sel_e'(pwdata[1:0]);
        RegInitialValue: init_q      <= pwdata;
        RegDetailLimit:  limit_q     <= pwdata[LimitBits-1:0];
        default:         ;
      endcase
    end
  end

  assign in_stall_o = fifo_full;
  assign accept     = in_valid_i && !in_stall_o;

  cpc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .start_check_i   (start_check_i),
    .width_sel_i     (width_sel_q),
    .initial_value_i (init_q),
    .push_o          (push),
    .item_o          (push_item)
  );

  cpc_fifo #(
    .Width (ItemBits),
    .Depth (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .rdata_o (pop_bits)
  );

  assign pop_item = cpc_item_t'(pop_bits);

  cpc_back #(
    .StatBits (STAT_COUNT_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_valid_i       (fifo_valid),
    .item_i             (pop_item),
    .pop_o              (pop),
    .detail_limit_i     (limit_q),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .value_offset_o     (value_offset_o),
    .expected_value_o   (expected_value_o),
    .received_value_o   (received_value_o),
    .mismatch_o         (mismatch_o),
    .skip_amount_o      (skip_amount_o),
    .detail_flag_o      (detail_flag_o),
    .first_suppressed_o (first_suppressed_o),
    .good_count_o       (good_count_o),
    .error_count_o      (error_count_o),
    .min_skip_o         (min_skip_o),
    .max_skip_o         (max_skip_o),
    .skip_total_o       (skip_total_o)
  );

endmodule

/* rtl/core/cpc_checker.sv */
// Port-level assertions for the counter pattern checker and their bind statement.
module cpc_checker import cpc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [ValueBits-1:0] expected_value_o,
  input logic [ValueBits-1:0] received_value_o,
  input logic                 mismatch_o,
  input logic [ValueBits-1:0] skip_amount_o,
  input logic                 detail_flag_o,
  input logic                 first_suppressed_o
);

  // A result that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result was withdrawn");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(received_value_o) && $stable(expected_value_o))
    else $error("stalled result changed");

  a_mismatch_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mismatch_o == (received_value_o != expected_value_o))
    else $error("mismatch flag disagrees with the values");

  // A matching counter carries no skip and no logging flags.
  a_match_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mismatch_o |->
      skip_amount_o == '0 && !detail_flag_o && !first_suppressed_o)
    else $error("match carries skip or logging flags");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(detail_flag_o && first_suppressed_o))
    else $error("detail and suppressed flags both set");

endmodule

bind counter_pattern_checker cpc_checker u_cpc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .expected_value_o   (expected_value_o),
  .received_value_o   (received_value_o),
  .mismatch_o         (mismatch_o),
  .skip_amount_o      (skip_amount_o),
  .detail_flag_o      (detail_flag_o),
  .first_suppressed_o (first_suppressed_o)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the counter pattern checker with a scoreboard class.
module tb_top import cpc_pkg::*;;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned PhaseItems   = 115;
  localparam int unsigned PhaseCount   = 12;
  localparam logic [1:0]  RegUnused    = 2'd3;

  typedef struct packed {
    logic [39:0] offset;
    logic [31:0] expected;
    logic [31:0] received;
    logic        mismatch;
    logic [31:0] skip;
    logic        detail;
    logic        first_sup;
    logic [39:0] good;
    logic [39:0] errors;
    logic [31:0] skip_lo;
    logic [31:0] skip_hi;
    logic [47:0] skip_total;
  } counter_result_t;

  class pattern_scoreboard;
    width_sel_e      width_sel;
    logic [31:0]     init_value;
    logic [15:0]     detail_limit;
    logic [23:0]     partial_bytes;
    logic [1:0]      byte_pos;
    logic [31:0]     expected_count;
    logic [31:0]     last_count;
    logic [39:0]     byte_offset;
    logic [39:0]     good_total;
    logic [39:0]     error_total;
    logic [31:0]     skip_min;
    logic [31:0]     skip_max;
    logic [47:0]     skip_sum;
    logic [15:0]     logged;
    bit              suppressed;
    counter_result_t expected_counters[$];
    int unsigned     fails;

    function new();
      width_sel    = WIDTH_8;
      init_value   = '0;
      detail_limit = DetailLimitReset;
      fails        = 0;
      restart_check();
    endfunction

    function int unsigned counter_bytes();
      case (width_sel)
        WIDTH_8:  return 1;
        WIDTH_16: return 2;
        default:  return 4;
      endcase
    endfunction

    function logic [31:0] counter_mask();
      case (width_sel)
        WIDTH_8:  return 32'h0000_00FF;
        WIDTH_16: return 32'h0000_FFFF;
        default:  return 32'hFFFF_FFFF;
      endcase
    endfunction

    function void restart_check();
      partial_bytes  = '0;
      byte_pos       = '0;
      expected_count = init_value & counter_mask();
      last_count     = init_value & counter_mask();
      byte_offset    = '0;
      good_total     = '0;
      error_total    = '0;
      skip_min       = '0;
      skip_max       = '0;
      skip_sum       = '0;
      logged         = '0;
      suppressed     = 1'b0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegWidthSelect:  width_sel = width_sel_e'(value[1:0]);
        RegInitialValue: init_value = value;
        RegDetailLimit:  detail_limit = value[15:0];
        default: ;
      endcase
    endfunction

    // Called for every accepted input transfer, in order of acceptance.
    function void note_byte(logic [7:0] b, bit start);
      int unsigned     pos;
      logic [31:0]     mask;
      logic [31:0]     rx;
      logic [31:0]     skip;
      logic [48:0]     sum_wide;
      counter_result_t r;
      if (start) restart_check();
      pos  = 32'(byte_pos);
      mask = counter_mask();
      if (pos + 1 < counter_bytes()) begin
        partial_bytes = 24'(32'(partial_bytes) | (32'(b) << (8 * pos)));
        byte_pos      = 2'(pos + 1);
        byte_offset   = byte_offset + 40'd1;
        return;
      end
      // A narrower width set mid-counter completes it here; upper bytes drop out.
      rx            = (32'(partial_bytes) | (32'(b) << (8 * pos))) & mask;
      r             = '0;
      r.offset      = byte_offset - 40'(pos);
      byte_offset   = byte_offset + 40'd1;
      partial_bytes = '0;
      byte_pos      = '0;
      r.expected    = expected_count;
      r.received    = rx;
      r.mismatch    = (rx != expected_count);
      if (!r.mismatch) begin
        if (good_total != '1) good_total = good_total + 40'd1;
      end else begin
        skip = (rx - last_count) & mask;
        if (error_total == '0) begin
          skip_min = skip;
          skip_max = skip;
        end else begin
          if (skip < skip_min) skip_min = skip;
          if (skip > skip_max) skip_max = skip;
        end
        if (error_total != '1) error_total = error_total + 40'd1;
        sum_wide = {1'b0, skip_sum} + 49'(skip);
        skip_sum = sum_wide[48] ? '1 : sum_wide[47:0];
        if (logged < detail_limit) begin
          r.detail = 1'b1;
          logged   = logged + 16'd1;
        end else if (!suppressed) begin
          r.first_sup = 1'b1;
          suppressed  = 1'b1;
        end
        r.skip = skip;
      end
      last_count     = rx;
      expected_count = (rx + 32'd1) & mask;
      r.good         = good_total;
      r.errors       = error_total;
      r.skip_lo      = skip_min;
      r.skip_hi      = skip_max;
      r.skip_total   = skip_sum;
      expected_counters.push_back(r);
    endfunction

    function void compare_field(string name, logic [47:0] exp_v, logic [47:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        fails++;
      end
    endfunction

    function void check_result(counter_result_t got);
      counter_result_t exp_r;
      if (expected_counters.size() == 0) begin
        $error("unexpected result transfer at offset %0h", got.offset);
        fails++;
        return;
      end
      exp_r = expected_counters.pop_front();
      compare_field("value_offset", 48'(exp_r.offset), 48'(got.offset));
      compare_field("expected_value", 48'(exp_r.expected), 48'(got.expected));
      compare_field("received_value", 48'(exp_r.received), 48'(got.received));
      compare_field("mismatch", 48'(exp_r.mismatch), 48'(got.mismatch));
      compare_field("skip_amount", 48'(exp_r.skip), 48'(got.skip));
      compare_field("detail_flag", 48'(exp_r.detail), 48'(got.detail));
      compare_field("first_suppressed", 48'(exp_r.first_sup), 48'(got.first_sup));
      compare_field("good_count", 48'(exp_r.good), 48'(got.good));
      compare_field("error_count", 48'(exp_r.errors), 48'(got.errors));
      compare_field("min_skip", 48'(exp_r.skip_lo), 48'(got.skip_lo));
      compare_field("max_skip", 48'(exp_r.skip_hi), 48'(got.skip_hi));
      compare_field("skip_total", exp_r.skip_total, got.skip_total);
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [AddrBits-1:0]    paddr         = '0;
  logic [31:0]            pwdata        = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic [7:0]             data_byte_i   = '0;
  logic                   start_check_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i   = 1'b0;
  logic [OffsetBits-1:0]  value_offset_o;
  logic [ValueBits-1:0]   expected_value_o;
  logic [ValueBits-1:0]   received_value_o;
  logic                   mismatch_o;
  logic [ValueBits-1:0]   skip_amount_o;
  logic                   detail_flag_o;
  logic                   first_suppressed_o;
  logic [39:0]            good_count_o;
  logic [39:0]            error_count_o;
  logic [ValueBits-1:0]   min_skip_o;
  logic [ValueBits-1:0]   max_skip_o;
  logic [SkipSumBits-1:0] skip_total_o;

  pattern_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  logic [31:0] next_count     = '0;

  counter_pattern_checker u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .start_check_i      (start_check_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .value_offset_o     (value_offset_o),
    .expected_value_o   (expected_value_o),
    .received_value_o   (received_value_o),
    .mismatch_o         (mismatch_o),
    .skip_amount_o      (skip_amount_o),
    .detail_flag_o      (detail_flag_o),
    .first_suppressed_o (first_suppressed_o),
    .good_count_o       (good_count_o),
    .error_count_o      (error_count_o),
    .min_skip_o         (min_skip_o),
    .max_skip_o         (max_skip_o),
    .skip_total_o       (skip_total_o)
  );

  always #4 clk_i = ~clk_i;

  // The receiver either stalls at random or serves a requested long hold-off.
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{offset: value_offset_o, expected: expected_value_o,
                        received: received_value_o, mismatch: mismatch_o,
                        skip: skip_amount_o, detail: detail_flag_o,
                        first_sup: first_suppressed_o, good: good_count_o,
                        errors: error_count_o, skip_lo: min_skip_o,
                        skip_hi: max_skip_o, skip_total: skip_total_o});
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrBits'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    start_check_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b, start);
  endtask

  // Bytes that only fill a partial counter leave no trace in the queue, so a
  // settle period follows before any register write.
  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (sb.expected_counters.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Mostly an incrementing stream at the current width, with skips, jumps,
  // backward steps, restarts and stray bytes that break the alignment.
  task automatic run_phase(input int unsigned n_items, input bit with_start,
                           input int unsigned hold_at, input int unsigned pause_at);
    int unsigned sent;
    int unsigned nb;
    int unsigned pick;
    int unsigned extra;
    logic [31:0] mask;
    bit          restart;
    sent    = 0;
    nb      = sb.counter_bytes();
    mask    = sb.counter_mask();
    restart = with_start;
    next_count = next_count & mask;
    while (sent < n_items) begin
      if (hold_at != 0 && sent >= hold_at) begin
        hold_requests++;
        hold_at = 0;
      end
      if (pause_at != 0 && sent >= pause_at) begin
        drain(0);
        pause_at = 0;
      end
      pick = $urandom_range(99);
      if (pick < 3) begin
        extra = $urandom_range(1, 3);
        repeat (extra) begin
          send_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
          sent++;
        end
        restart = 1'b1;
        continue;
      end
      if (restart) next_count = sb.init_value;
      else if (pick < 8) next_count = $urandom;
      else if (pick < 12) next_count = next_count + 32'($urandom_range(2, 5));
      else if (pick < 14) next_count = next_count - 32'($urandom_range(1, 3));
      next_count = next_count & mask;
      for (int i = 0; i < nb; i++) begin
        send_byte(next_count[8*i +: 8], restart && (i == 0));
        sent++;
      end
      restart    = ($urandom_range(99) < 2);
      next_count = (next_count + 32'd1) & mask;
    end
  endtask

  initial begin : stimulus
    logic [31:0] init_val;
    logic [15:0] limit_val;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: 8-bit counters, match, mismatch and wrap.
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    drain(SettleCycles);

    // 16-bit counters, initial value wider than the counter, zero limit.
    write_reg(RegWidthSelect, {30'h0, WIDTH_16});
    write_reg(RegInitialValue, 32'h1234_FFFF);
    write_reg(RegDetailLimit, 32'h0000_0000);
    write_reg(RegUnused, 32'hDEAD_BEEF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    drain(SettleCycles);

    // Narrowing the width with a partial counter pending completes it.
    write_reg(RegWidthSelect, {30'h0, WIDTH_8});
    send_byte(8'h55, 1'b0);
    drain(SettleCycles);

    // Width code 3 behaves as 32 bits; limit of one.
    write_reg(RegWidthSelect, {30'h0, WIDTH_32_ALT});
    write_reg(RegInitialValue, 32'hFFFF_FFFF);
    write_reg(RegDetailLimit, 32'h0000_0001);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    drain(SettleCycles);

    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 4) begin
        send_idle_pct  = 12;
        recv_stall_pct = 88;
      end else if (p < 8) begin
        send_idle_pct  = 88;
        recv_stall_pct = 12;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (p % 3)
        0:       init_val = 32'h0000_0000;
        1:       init_val = 32'hFFFF_FFFF;
        default: init_val = $urandom;
      endcase
      case (p % 5)
        0:       limit_val = 16'd0;
        1:       limit_val = 16'd1;
        2:       limit_val = 16'($urandom_range(2, 8));
        3:       limit_val = 16'hFFFF;
        default: limit_val = 16'($urandom_range(0, 20));
      endcase
      write_reg(RegWidthSelect, {30'($urandom), 2'(p % 4)});
      write_reg(RegInitialValue, init_val);
      write_reg(RegDetailLimit, {16'($urandom), limit_val});
      write_reg(RegUnused, $urandom);
      run_phase(PhaseItems, (p != 0) && ($urandom_range(3) != 0),
                (p == 8) ? 30 : 0, (p == 10) ? 60 : 0);
      drain(SettleCycles);
    end

    drain(SettleCycles);
    if (sb.fails == 0 && sb.expected_counters.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* counter_pattern_checker.f */
rtl/core/cpc_pkg.sv
rtl/core/cpc_fifo.sv
rtl/core/cpc_front.sv
rtl/core/cpc_back.sv
rtl/core/counter_pattern_checker.sv
rtl/core/cpc_checker.sv
tb/sv/tb_top.sv
